/* rtl/core/fat12ccb_pkg.sv */
package fat12ccb_pkg;

  // command codes
  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_ADD     = 2'd1;
  localparam logic [1:0] ACT_ENTRY   = 2'd2;
  localparam logic [1:0] ACT_BYTE    = 2'd3;

  localparam int unsigned IDX_W      = 9;
  localparam int unsigned VAL_W      = 12;
  localparam int unsigned HDR_BYTES  = 5;

  localparam logic [11:0] END_MARK   = 12'hFFF;
  localparam logic [7:0]  LO_MASK    = 8'h0F;
  localparam logic [7:0]  HI_MASK    = 8'hF0;

  typedef struct packed {
    logic [1:0]       action;
    logic [31:0]      file_size;
    logic [IDX_W-1:0] entry_index;
    logic [IDX_W-1:0] byte_address;
  } cmd_word_t;

  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] read_value;
  } rsp_word_t;

  // media header bytes at the start of the table
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'hF8;
      3'd1:    b = 8'hFF;
      3'd2:    b = 8'hFF;
      3'd3:    b = 8'hFF;
      3'd4:    b = 8'h0F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/fat12ccb_table.sv */
module fat12ccb_table #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/fat12_cluster_chain_builder.sv */
// fat12 allocation table with a cluster chain builder
//
// command channel: cmd is taken at a rising edge with start high and busy low.
// busy stays high while a command is in work; one result word per command
// comes back on result, marked by done for exactly one cycle. the receiver
// cannot hold results off, and none is needed: the block never has more than
// one result pending.
//
// each cluster is placed in order: offset calc, read of the shared byte, then two byte writes.
//
// after reset the table is swept back to the media header and zeros, one
// byte per cycle over all TABLE_BYTES bytes; busy is high during the sweep.
module fat12_cluster_chain_builder #(
  parameter int TABLE_BYTES   = 512,
  parameter int CLUSTER_BYTES = 512
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  fat12ccb_pkg::cmd_word_t  cmd,
  output logic                     busy,
  output logic                     done,
  output fat12ccb_pkg::rsp_word_t  result
);

  import fat12ccb_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_BYTES);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int OFF_W  = ((ADDR_W > IDX_W + 1) ? ADDR_W : IDX_W + 1) + 1;
  localparam logic [OFF_W-1:0] T_LIM   = OFF_W'(TABLE_BYTES);
  localparam logic [OFF_W-1:0] T_LAST  = OFF_W'(TABLE_BYTES - 1);
  localparam logic [OFF_W-1:0] HDR_LIM = OFF_W'(HDR_BYTES);
  localparam logic [31:0]      CLU_SZ  = 32'(CLUSTER_BYTES);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_A_CALC = 10'b0000000100,
    S_A_READ = 10'b0000001000,
    S_A_WR0  = 10'b0000010000,
    S_A_WR1  = 10'b0000100000,
    S_E_RD0  = 10'b0001000000,
    S_E_RD1  = 10'b0010000000,
    S_E_OUT  = 10'b0100000000,
    S_B_OUT  = 10'b1000000000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;       // last cluster handed out
  logic [CNT_W-1:0] nxt;       // cluster being allocated
  logic [OFF_W-1:0] off;       // byte offset of the entry, or sweep address
  logic [31:0]      left;      // bytes of the file still to place
  logic [11:0]      val;       // entry value being written
  logic [7:0]       b0;        // first byte of an entry read
  logic             par;       // odd entry on a read
  logic [1:0]       act;       // command in work

  logic [CNT_W-1:0] nxt_c;
  logic [OFF_W-1:0] off_inc;
  logic [OFF_W-1:0] idx_off;
  logic             accept;

  // table port
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign nxt_c   = cnt + 1'b1;
  assign off_inc = off + 1'b1;
  // 3n/2 rounded down is n plus half of n
  assign idx_off = OFF_W'(cmd.entry_index) + OFF_W'(cmd.entry_index >> 1);

  fat12ccb_table #(
    .DEPTH (TABLE_BYTES),
    .AW    (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // table port control
  always_comb begin
    we    = 1'b0;
    waddr = off[ADDR_W-1:0];
    wdata = 8'h00;
    re    = 1'b0;
    raddr = off[ADDR_W-1:0];
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        wdata = (off < HDR_LIM) ? hdr_byte(off[2:0]) : 8'h00;
      end
      S_A_READ: begin
        // fetch the byte shared with the neighbor entry
        re = (off_inc < T_LIM);
        if (!nxt[0]) begin
          raddr = off_inc[ADDR_W-1:0];
        end
      end
      S_A_WR0: begin
        we = 1'b1;
        if (nxt[0]) begin
          wdata = (rdata & LO_MASK) | ({val[3:0], 4'h0} & HI_MASK);
        end else begin
          wdata = val[7:0];
        end
      end
      S_A_WR1: begin
        we    = 1'b1;
        waddr = off_inc[ADDR_W-1:0];
        if (nxt[0]) begin
          wdata = val[11:4];
        end else begin
          wdata = (rdata & HI_MASK) | {4'h0, val[11:8]};
        end
      end
      S_E_RD0: begin
        re = 1'b1;
      end
      S_E_RD1: begin
        // entry read fetches its second byte, byte read fetches at off
        re = 1'b1;
        if (act != ACT_BYTE) begin
          raddr = off_inc[ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      off   <= '0;
      cnt   <= CNT_W'(1);
      done  <= 1'b0;
      act   <= ACT_RESTART;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          off <= off_inc;
          if (off == T_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            act <= cmd.action;
            result.status     <= 1'b0;
            result.read_value <= '0;
            case (cmd.action)
              ACT_RESTART: begin
                cnt  <= CNT_W'(1);
                done <= 1'b1;
              end
              ACT_ADD: begin
                left <= cmd.file_size;
                if (cmd.file_size == 32'd0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_A_CALC;
                end
              end
              ACT_ENTRY: begin
                off <= idx_off;
                par <= cmd.entry_index[0];
                if (idx_off + 1'b1 < T_LIM) begin
                  state <= S_E_RD0;
                end else begin
                  done <= 1'b1;
                end
              end
              ACT_BYTE: begin
                off <= OFF_W'(cmd.byte_address);
                if (OFF_W'(cmd.byte_address) < T_LIM) begin
                  state <= S_E_RD1;
                  // byte read reuses the second fetch slot, addressed at off
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_A_CALC: begin
          nxt <= nxt_c;
          off <= OFF_W'(nxt_c) + OFF_W'(nxt_c >> 1);
          state <= S_A_READ;
        end
        S_A_READ: begin
          if (off_inc < T_LIM) begin
            cnt <= nxt;
            if (left > CLU_SZ) begin
              val  <= 12'(nxt + 1'b1);
              left <= left - CLU_SZ;
            end else begin
              val  <= END_MARK;
              left <= 32'd0;
            end
            state <= S_A_WR0;
          end else begin
            // next entry would not fit: stop, counter keeps its value
            result.status <= 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_A_WR0: begin
          state <= S_A_WR1;
        end
        S_A_WR1: begin
          if (left == 32'd0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_A_CALC;
          end
        end
        S_E_RD0: begin
          state <= S_E_RD1;
        end
        S_E_RD1: begin
          // entry read: byte at off arrives now; byte read: no fetch yet
          b0 <= rdata;
          if (act == ACT_BYTE) begin
            state <= S_B_OUT;
          end else begin
            state <= S_E_OUT;
          end
        end
        S_E_OUT: begin
          if (par) begin
            result.read_value <= {rdata, b0[7:4]};
          end else begin
            result.read_value <= {rdata[3:0], b0};
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_B_OUT: begin
          result.read_value <= {4'h0, rdata};
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result word while a command is in work");

  a_status_add: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (act == ACT_ADD))
    else $error("full status on a command other than add file");

  a_entry_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_WR0 || state == S_A_WR1) |-> (off_inc < T_LIM))
    else $error("entry write past the end of the table");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("table written while idle");

endmodule
